/* hw/rtl/psna_pkg.sv */
// Shared types, codes and the reciprocal table of the pixel store neighbour average block.
package psna_pkg;

  // One stored pixel, red in the top bits and status in the bottom two.
  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [1:0] status;
  } pix_t;

  // Port strobes of the frame store.
  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } store_ctl_t;

  // Operation codes carried in the input item.
  localparam logic [1:0] OP_WRITE      = 2'd0;
  localparam logic [1:0] OP_AVERAGE    = 2'd1;
  localparam logic [1:0] OP_NEIGHBOURS = 2'd2;

  // Pixel status codes.
  localparam logic [1:0] ST_BLANK = 2'd0;
  localparam logic [1:0] ST_SET   = 2'd1;

  // Configuration register indexes.
  localparam logic CFG_MAP_WIDTH  = 1'b0;
  localparam logic CFG_MAP_HEIGHT = 1'b1;

  // Arithmetic widths: nine 8-bit channels plus half the count fit in 12 bits.
  localparam int SUM_W       = 12;
  localparam int CNT_W       = 4;
  localparam int RECIP_W     = 17;
  localparam int RECIP_SHIFT = 16;
  localparam int PROD_W      = SUM_W + RECIP_W;

  // Rounded-up 2^16 / n for n in 1..9. For dividends below 4096 the product
  // shifted down by 16 is the exact floor quotient. A count of zero gives zero.
  function automatic logic [RECIP_W-1:0] recip(input logic [CNT_W-1:0] n);
    logic [RECIP_W-1:0] r;
    case (n)
      4'd1:    r = 17'd65536;
      4'd2:    r = 17'd32768;
      4'd3:    r = 17'd21846;
      4'd4:    r = 17'd16384;
      4'd5:    r = 17'd13108;
      4'd6:    r = 17'd10923;
      4'd7:    r = 17'd9363;
      4'd8:    r = 17'd8192;
      4'd9:    r = 17'd7282;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

/* hw/rtl/psna_frame_store.sv */
// Frame store memory with one write port and one registered read port.
module psna_frame_store #(
  parameter int DEPTH  = 65536,
  parameter int ADDR_W = 16
) (
  input  logic                clk,
  input  psna_pkg::store_ctl_t ctl,
  input  logic [ADDR_W-1:0]   wr_addr,
  input  psna_pkg::pix_t      wr_data,
  input  logic [ADDR_W-1:0]   rd_addr,
  output psna_pkg::pix_t      rd_data
);
  import psna_pkg::*;

  pix_t mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port, data valid the cycle after the request.
  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* hw/rtl/pixel_store_neighbour_average.sv */
// Top level of the pixel store neighbour average block.
//
// The block holds a MAX_WIDTH x MAX_HEIGHT frame store of RGB pixels with a
// status. After reset it clears all MAX_WIDTH*MAX_HEIGHT locations and takes
// no item meanwhile; configuration writes are taken at any time. A write item
// finishes in the accept cycle and the next item may follow at once. For an
// average item the 3x3 window is read from the single read port of the frame
// store, one pixel a cycle, and the three channel means then pass one after
// another through a shared reciprocal multiplier. A neighbour item scans the
// window and then walks it one position a cycle, waiting at a blank neighbour
// while the output register is full, up to the last blank neighbour: one item
// per blank neighbour, or one item marked invalid if none. While an item is in
// work in_tready is low; a finished result waits in the output register.
module pixel_store_neighbour_average #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  // Input item.
  input  logic        in_tvalid,
  output logic        in_tready,
  // tdata from bit 0: x_pos[7:0], y_pos[7:0], red_in[7:0], green_in[7:0],
  // blue_in[7:0], status_in[1:0], zero fill.
  input  logic [47:0] in_tdata,
  // tuser: operation[1:0].
  input  logic [1:0]  in_tuser,
  // Result item.
  output logic        out_tvalid,
  input  logic        out_tready,
  // tdata from bit 0: avg_red[7:0], avg_green[7:0], avg_blue[7:0],
  // set_count[3:0], neighbour_x[7:0], neighbour_y[7:0], zero fill.
  output logic [47:0] out_tdata,
  // tuser: neighbour_valid.
  output logic [0:0]  out_tuser,
  output logic        out_tlast,
  // Configuration writes.
  input  logic        cfg_we,
  input  logic        cfg_addr,
  input  logic [8:0]  cfg_wdata
);
  import psna_pkg::*;

  localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W = $clog2(DEPTH);

  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_SCAN   = 3'd2;
  localparam logic [2:0] S_DIV    = 3'd3;
  localparam logic [2:0] S_AVGOUT = 3'd4;
  localparam logic [2:0] S_LIST   = 3'd5;

  // Control registers.
  logic [2:0]        state_r, state_nxt;
  logic [ADDR_W-1:0] clr_cnt_r, clr_cnt_nxt;
  logic              step_vld_r, step_vld_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [8:0]        map_width_r, map_width_nxt;
  logic [8:0]        map_height_r, map_height_nxt;

  // Working registers.
  logic [1:0]        op_r, op_nxt;
  logic [7:0]        x_r, x_nxt;
  logic [7:0]        y_r, y_nxt;
  logic [1:0]        ix_r, ix_nxt;
  logic [1:0]        iy_r, iy_nxt;
  logic              issue_done_r, issue_done_nxt;
  logic              step_in_r, step_in_nxt;
  logic              step_ctr_r, step_ctr_nxt;
  logic [SUM_W-1:0]  sum_r [3];
  logic [SUM_W-1:0]  sum_nxt [3];
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [8:0]        mask_r, mask_nxt;
  logic [1:0]        div_c_r, div_c_nxt;
  logic [PROD_W-1:0] prod_r, prod_nxt;
  logic [7:0]        q_r [3];
  logic [7:0]        q_nxt [3];

  // Output register.
  logic [7:0]        out_red_r, out_red_nxt;
  logic [7:0]        out_green_r, out_green_nxt;
  logic [7:0]        out_blue_r, out_blue_nxt;
  logic [CNT_W-1:0]  out_cnt_r, out_cnt_nxt;
  logic [7:0]        out_nx_r, out_nx_nxt;
  logic [7:0]        out_ny_r, out_ny_nxt;
  logic              out_nvalid_r, out_nvalid_nxt;
  logic              out_last_r, out_last_nxt;

  // Frame store connections.
  store_ctl_t        st_ctl;
  logic [ADDR_W-1:0] st_wr_addr;
  pix_t              st_wr_data;
  logic [ADDR_W-1:0] st_rd_addr;
  pix_t              st_rd_data;

  // Combinational helpers.
  logic [8:0]        eff_w, eff_h;
  logic              accept, out_free;
  logic [1:0]        in_op;
  logic [7:0]        in_x, in_y;
  pix_t              in_pix;
  logic              in_inmap;
  logic [9:0]        nx_full, ny_full;
  logic              n_inmap;
  logic [1:0]        div_sel;
  logic [SUM_W-1:0]  dividend;
  logic [RECIP_W-1:0] recip_v;
  logic              list_last;

  psna_frame_store #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W)
  ) u_store (
    .clk     (clk),
    .ctl     (st_ctl),
    .wr_addr (st_wr_addr),
    .wr_data (st_wr_data),
    .rd_addr (st_rd_addr),
    .rd_data (st_rd_data)
  );

  // Effective map size: register value saturated to the store size.
  assign eff_w = (32'(map_width_r) > MAX_WIDTH) ? 9'(MAX_WIDTH) : map_width_r;
  assign eff_h = (32'(map_height_r) > MAX_HEIGHT) ? 9'(MAX_HEIGHT) : map_height_r;

  // Input item fields.
  assign in_op         = in_tuser;
  assign in_x          = in_tdata[7:0];
  assign in_y          = in_tdata[15:8];
  assign in_pix.red    = in_tdata[23:16];
  assign in_pix.green  = in_tdata[31:24];
  assign in_pix.blue   = in_tdata[39:32];
  assign in_pix.status = in_tdata[41:40];
  assign in_inmap      = ({1'b0, in_x} < eff_w) && ({1'b0, in_y} < eff_h);

  assign in_tready = (state_r == S_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;

  // Window position under the scan counters, offset by minus one on each axis.
  assign nx_full = {2'b00, x_r} + {8'b0, ix_r} - 10'd1;
  assign ny_full = {2'b00, y_r} + {8'b0, iy_r} - 10'd1;
  assign n_inmap = !nx_full[9] && (nx_full[8:0] < eff_w) &&
                   !ny_full[9] && (ny_full[8:0] < eff_h);

  // Shared multiplier operands for the channel means.
  assign div_sel   = (div_c_r == 2'd3) ? 2'd2 : div_c_r;
  assign dividend  = sum_r[div_sel] + SUM_W'(cnt_r >> 1);
  assign recip_v   = recip(cnt_r);
  assign list_last = (mask_r[8:1] == 8'd0);

  // Frame store port drive.
  always_comb begin
    st_ctl.wr_en = 1'b0;
    st_ctl.rd_en = 1'b0;
    st_wr_addr   = clr_cnt_r;
    st_wr_data   = '0;
    st_rd_addr   = ADDR_W'(32'(nx_full[7:0]) * MAX_HEIGHT + 32'(ny_full[7:0]));
    if (state_r == S_CLEAR) begin
      st_ctl.wr_en = 1'b1;
    end else if (accept && (in_op == OP_WRITE) && in_inmap) begin
      st_ctl.wr_en = 1'b1;
      st_wr_addr   = ADDR_W'(32'(in_x) * MAX_HEIGHT + 32'(in_y));
      st_wr_data   = in_pix;
    end
    if ((state_r == S_SCAN) && !issue_done_r) begin
      st_ctl.rd_en = n_inmap;
    end
  end

  // Sequencer and datapath next state.
  always_comb begin
    state_nxt      = state_r;
    clr_cnt_nxt    = clr_cnt_r;
    step_vld_nxt   = 1'b0;
    out_valid_nxt  = out_valid_r && !out_tready;
    map_width_nxt  = map_width_r;
    map_height_nxt = map_height_r;
    op_nxt         = op_r;
    x_nxt          = x_r;
    y_nxt          = y_r;
    ix_nxt         = ix_r;
    iy_nxt         = iy_r;
    issue_done_nxt = issue_done_r;
    step_in_nxt    = step_in_r;
    step_ctr_nxt   = step_ctr_r;
    sum_nxt        = sum_r;
    cnt_nxt        = cnt_r;
    mask_nxt       = mask_r;
    div_c_nxt      = div_c_r;
    prod_nxt       = prod_r;
    q_nxt          = q_r;
    out_red_nxt    = out_red_r;
    out_green_nxt  = out_green_r;
    out_blue_nxt   = out_blue_r;
    out_cnt_nxt    = out_cnt_r;
    out_nx_nxt     = out_nx_r;
    out_ny_nxt     = out_ny_r;
    out_nvalid_nxt = out_nvalid_r;
    out_last_nxt   = out_last_r;

    // Configuration writes are taken in any state.
    if (cfg_we) begin
      case (cfg_addr)
        CFG_MAP_WIDTH:  map_width_nxt  = cfg_wdata;
        CFG_MAP_HEIGHT: map_height_nxt = cfg_wdata;
        default:        map_width_nxt  = map_width_r;
      endcase
    end

    case (state_r)
      S_CLEAR: begin
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == ADDR_W'(DEPTH - 1)) begin
          state_nxt = S_IDLE;
        end
      end

      S_IDLE: begin
        // Writes finish in the accept cycle; the unused code is dropped.
        if (accept && ((in_op == OP_AVERAGE) || (in_op == OP_NEIGHBOURS))) begin
          op_nxt         = in_op;
          x_nxt          = in_x;
          y_nxt          = in_y;
          ix_nxt         = 2'd0;
          iy_nxt         = 2'd0;
          issue_done_nxt = 1'b0;
          sum_nxt[0]     = '0;
          sum_nxt[1]     = '0;
          sum_nxt[2]     = '0;
          cnt_nxt        = '0;
          mask_nxt       = '0;
          state_nxt      = S_SCAN;
        end
      end

      S_SCAN: begin
        // Issue one window read a cycle, dx outer and dy inner.
        if (!issue_done_r) begin
          step_vld_nxt = 1'b1;
          step_in_nxt  = n_inmap;
          step_ctr_nxt = (ix_r == 2'd1) && (iy_r == 2'd1);
          if (iy_r == 2'd2) begin
            iy_nxt = 2'd0;
            if (ix_r == 2'd2) begin
              issue_done_nxt = 1'b1;
            end else begin
              ix_nxt = ix_r + 2'd1;
            end
          end else begin
            iy_nxt = iy_r + 2'd1;
          end
        end
        // Take in the pixel read on the previous cycle.
        if (step_vld_r) begin
          if (step_in_r && (st_rd_data.status == ST_SET)) begin
            sum_nxt[0] = sum_r[0] + SUM_W'(st_rd_data.red);
            sum_nxt[1] = sum_r[1] + SUM_W'(st_rd_data.green);
            sum_nxt[2] = sum_r[2] + SUM_W'(st_rd_data.blue);
            cnt_nxt    = cnt_r + 1'b1;
          end
          mask_nxt = {step_in_r && !step_ctr_r && (st_rd_data.status == ST_BLANK),
                      mask_r[8:1]};
          if (issue_done_r) begin
            ix_nxt    = 2'd0;
            iy_nxt    = 2'd0;
            div_c_nxt = 2'd0;
            state_nxt = (op_r == OP_AVERAGE) ? S_DIV : S_LIST;
          end
        end
      end

      S_DIV: begin
        // One channel a cycle through the multiplier; the quotient is taken from the registered product.
        prod_nxt = PROD_W'(dividend) * PROD_W'(recip_v);
        if (div_c_r != 2'd0) begin
          q_nxt[2'(div_c_r - 2'd1)] = prod_r[RECIP_SHIFT +: 8];
        end
        if (div_c_r == 2'd3) begin
          state_nxt = S_AVGOUT;
        end else begin
          div_c_nxt = div_c_r + 2'd1;
        end
      end

      S_AVGOUT: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_red_nxt    = q_r[0];
          out_green_nxt  = q_r[1];
          out_blue_nxt   = q_r[2];
          out_cnt_nxt    = cnt_r;
          out_nx_nxt     = '0;
          out_ny_nxt     = '0;
          out_nvalid_nxt = 1'b0;
          out_last_nxt   = 1'b1;
          state_nxt      = S_IDLE;
        end
      end

      S_LIST: begin
        if (mask_r == 9'd0) begin
          // No blank neighbour: one item marked invalid.
          if (out_free) begin
            out_valid_nxt  = 1'b1;
            out_red_nxt    = '0;
            out_green_nxt  = '0;
            out_blue_nxt   = '0;
            out_cnt_nxt    = '0;
            out_nx_nxt     = '0;
            out_ny_nxt     = '0;
            out_nvalid_nxt = 1'b0;
            out_last_nxt   = 1'b1;
            state_nxt      = S_IDLE;
          end
        end else if (!mask_r[0] || out_free) begin
          // Walk the window; emit where the blank mask is set.
          if (mask_r[0]) begin
            out_valid_nxt  = 1'b1;
            out_red_nxt    = '0;
            out_green_nxt  = '0;
            out_blue_nxt   = '0;
            out_cnt_nxt    = '0;
            out_nx_nxt     = nx_full[7:0];
            out_ny_nxt     = ny_full[7:0];
            out_nvalid_nxt = 1'b1;
            out_last_nxt   = list_last;
            if (list_last) begin
              state_nxt = S_IDLE;
            end
          end
          mask_nxt = {1'b0, mask_r[8:1]};
          if (iy_r == 2'd2) begin
            iy_nxt = 2'd0;
            ix_nxt = ix_r + 2'd1;
          end else begin
            iy_nxt = iy_r + 2'd1;
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers with reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      clr_cnt_r    <= '0;
      step_vld_r   <= 1'b0;
      out_valid_r  <= 1'b0;
      map_width_r  <= 9'd256;
      map_height_r <= 9'd256;
    end else begin
      state_r      <= state_nxt;
      clr_cnt_r    <= clr_cnt_nxt;
      step_vld_r   <= step_vld_nxt;
      out_valid_r  <= out_valid_nxt;
      map_width_r  <= map_width_nxt;
      map_height_r <= map_height_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    x_r          <= x_nxt;
    y_r          <= y_nxt;
    ix_r         <= ix_nxt;
    iy_r         <= iy_nxt;
    issue_done_r <= issue_done_nxt;
    step_in_r    <= step_in_nxt;
    step_ctr_r   <= step_ctr_nxt;
    sum_r        <= sum_nxt;
    cnt_r        <= cnt_nxt;
    mask_r       <= mask_nxt;
    div_c_r      <= div_c_nxt;
    prod_r       <= prod_nxt;
    q_r          <= q_nxt;
    out_red_r    <= out_red_nxt;
    out_green_r  <= out_green_nxt;
    out_blue_r   <= out_blue_nxt;
    out_cnt_r    <= out_cnt_nxt;
    out_nx_r     <= out_nx_nxt;
    out_ny_r     <= out_ny_nxt;
    out_nvalid_r <= out_nvalid_nxt;
    out_last_r   <= out_last_nxt;
  end

  // Result item.
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0000, out_ny_r, out_nx_r, out_cnt_r,
                       out_blue_r, out_green_r, out_red_r};
  assign out_tuser  = out_nvalid_r;
  assign out_tlast  = out_last_r;

endmodule

/* hw/rtl/psna_checker.sv */
// Port-level checks of the pixel store neighbour average block and their bind.
module psna_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [47:0] in_tdata,
  input logic [1:0]  in_tuser,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [47:0] out_tdata,
  input logic [0:0]  out_tuser,
  input logic        out_tlast,
  input logic        cfg_we,
  input logic        cfg_addr,
  input logic [8:0]  cfg_wdata
);
  import psna_pkg::*;

  // A stalled result item holds its contents.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) &&
    $stable(out_tuser) && $stable(out_tlast))
    else $error("result item changed while stalled");

  // An average or neighbour item keeps the input closed on the next cycle.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && ((in_tuser == OP_AVERAGE) || (in_tuser == OP_NEIGHBOURS))
    |=> !in_tready)
    else $error("input open while an item is in work");

  // Items without a neighbour coordinate are always the final item.
  a_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |-> out_tlast)
    else $error("average or empty list item not marked last");

  // Neighbour items carry no averages, and a count never exceeds the window.
  a_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[27:24] <= 4'd9) &&
    (!out_tuser[0] || (out_tdata[27:0] == 28'd0)))
    else $error("result fields inconsistent with item kind");

endmodule

bind pixel_store_neighbour_average psna_checker u_psna_checker (.*);
